### hdl/sks_pkg.sv
// Shared constants, codes and control structs for the session key slot store.
package sks_pkg;

  localparam int SLOTS     = 16;
  localparam int KEY_BYTES = 32;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WORD_W    = 64;
  localparam int KEY_W     = 4 * WORD_W;   // four key words per slot
  localparam int LEN_W     = 6;            // stored length field
  localparam int ID_W      = 32;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_GET     = 2'd1,
    OP_DESTROY = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARG   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_NO_SPACE  = 3'd4
  } status_t;

  // Tag table update command.
  typedef struct packed {
    logic              we;
    logic              clr_all;
    logic [SLOT_W-1:0] idx;
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } tag_wr_t;

  // Tag table lookup result.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [LEN_W-1:0]  hit_len;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } tag_rsp_t;

endpackage

### hdl/sks_tag_table.sv
// Slot tags: valid bits, local ids and lengths with parallel handle match.
module sks_tag_table import sks_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ID_W-1:0]   session,
  input  logic [63:0]       handle,
  input  tag_wr_t           wr,
  output tag_rsp_t          rsp
);

  logic             valid_r [SLOTS];
  logic [ID_W-1:0]  id_r    [SLOTS];
  logic [LEN_W-1:0] len_r   [SLOTS];
  logic [SLOTS-1:0] match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) valid_r[s] <= 1'b0;
    end else if (wr.clr_all) begin
      for (int s = 0; s < SLOTS; s++) valid_r[s] <= 1'b0;
    end else if (wr.we) begin
      valid_r[wr.idx] <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      id_r[wr.idx]  <= wr.id;
      len_r[wr.idx] <= wr.len;
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = valid_r[s] && (handle[63:32] == session) && (handle[31:0] == id_r[s]);
    end
  end

  // lowest index wins on both searches
  always_comb begin
    rsp = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (match[s]) begin
        rsp.hit     = 1'b1;
        rsp.hit_idx = SLOT_W'(s);
      end
      if (!valid_r[s]) begin
        rsp.free_found = 1'b1;
        rsp.free_idx   = SLOT_W'(s);
      end
    end
    rsp.hit_len = len_r[rsp.hit_idx];
  end

endmodule

### hdl/sks_key_ram.sv
// Key word memory, one slot per entry, registered read.
module sks_key_ram import sks_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [KEY_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [KEY_W-1:0]  rd_data
);

  logic [KEY_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### hdl/session_key_slot_store.sv
// Top level of the session key slot store: control sequencer and result register.
//
// Channels:
//   cfg_*  : write beat sets the 32-bit session number (upper half of every
//            handle). Always ready; write only while the block is idle.
//   in_*   : request beat. tuser carries the opcode (create, get, destroy,
//            clear all); tdata carries handle, length and up to 32 key bytes.
//   out_*  : one result beat per request. tuser carries the status code.
// Timing: a beat is taken in IDLE; the tag compare and decision happen in
//   LOOK, which ends create, destroy, clear-all and failed gets. A successful
//   get goes on to READ for the registered key memory read, which the key
//   memory port sets.
// The result sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, the next request holds in its decide
//   step until the output register frees up.
// Reset (synchronous, rst_n low): all slots invalid, counter and session
//   number zero, no result pending. No memory sweep is needed: slot contents
//   are only read behind a valid bit. Destroy writes zeros to its slot.
module session_key_slot_store import sks_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,      // session_number
  // request stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [327:0] in_tdata,      // key_handle, key_length, in_word_0..3
  input  logic [1:0]   in_tuser,      // opcode
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [327:0] out_tdata,     // issued_handle, stored_length, out_word_0..3, pad
  output logic [2:0]   out_tuser      // status
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_READ} state_t;

  state_t           state_r;
  logic [ID_W-1:0]  session_r;
  logic [ID_W-1:0]  cnt_r;

  // latched request
  opcode_t          op_r;
  logic [63:0]      handle_r;
  logic [7:0]       len_r;
  logic [KEY_W-1:0] key_r;

  // result register
  logic             out_valid_r;
  status_t          out_status_r;
  logic [63:0]      out_handle_r;
  logic [LEN_W-1:0] out_len_r;
  logic [KEY_W-1:0] out_key_r;

  tag_wr_t          tag_wr;
  tag_rsp_t         tag_rsp;
  logic [KEY_W-1:0] ram_rd_data;
  logic             ram_we, ram_re;
  logic [SLOT_W-1:0] ram_addr;
  logic [KEY_W-1:0] ram_wdata;

  // decision in S_LOOK
  status_t          res_status;
  logic [63:0]      res_handle;
  logic [LEN_W-1:0] res_len;
  logic             go_read;
  logic             bump_cnt;
  logic             out_free, fire;
  logic             out_set;
  logic [ID_W-1:0]  cnt_add, cnt_inc;
  logic [KEY_W-1:0] key_masked;
  logic             in_beat;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = (state_r == S_LOOK) && out_free;
  // result register loads on a finished decision or a finished key read
  assign out_set   = (fire && !go_read) || ((state_r == S_READ) && out_free);

  assign cnt_add = cnt_r + 32'd1;
  assign cnt_inc = (cnt_add == '0) ? 32'd1 : cnt_add;   // counter skips zero

  // keep only the supplied bytes
  always_comb begin
    for (int i = 0; i < KEY_W / 8; i++) begin
      key_masked[8*i +: 8] = (8'(i) < len_r) ? key_r[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_handle = '0;
    res_len    = '0;
    go_read    = 1'b0;
    bump_cnt   = 1'b0;
    tag_wr     = '0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    ram_addr   = tag_rsp.hit_idx;
    unique case (op_r)
      OP_CREATE: begin
        ram_addr = tag_rsp.free_idx;
        if (len_r == 8'd0 || len_r > 8'(KEY_BYTES)) begin
          res_status = ST_BAD_ARG;
        end else if (!tag_rsp.free_found) begin
          res_status = ST_NO_SPACE;
        end else begin
          res_handle   = {session_r, cnt_inc};
          bump_cnt     = fire;
          tag_wr.we    = fire;
          tag_wr.idx   = tag_rsp.free_idx;
          tag_wr.valid = 1'b1;
          tag_wr.id    = cnt_inc;
          tag_wr.len   = len_r[LEN_W-1:0];
          ram_we       = fire;
          ram_wdata    = key_masked;
        end
      end
      OP_GET: begin
        if (handle_r == '0) begin
          res_status = ST_BAD_ARG;
        end else if (!tag_rsp.hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_len = tag_rsp.hit_len;
          if (len_r < {2'b00, tag_rsp.hit_len}) res_status = ST_TOO_SMALL;
          else go_read = 1'b1;
        end
      end
      OP_DESTROY: begin
        if (handle_r == '0) begin
          res_status = ST_BAD_ARG;
        end else if (!tag_rsp.hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          tag_wr.we  = fire;
          tag_wr.idx = tag_rsp.hit_idx;
          ram_we     = fire;   // zeroize key words
        end
      end
      OP_CLEAR: begin
        tag_wr.clr_all = fire;
      end
      default: res_status = ST_OK;
    endcase
  end

  assign ram_re = fire && go_read;

  sks_tag_table u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .session (session_r),
    .handle  (handle_r),
    .wr      (tag_wr),
    .rsp     (tag_rsp)
  );

  sks_key_ram u_keys (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r     <= opcode_t'(in_tuser);
      handle_r <= in_tdata[63:0];
      len_r    <= in_tdata[71:64];
      key_r    <= in_tdata[327:72];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      session_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (bump_cnt) begin
      cnt_r <= cnt_inc;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) state_r <= S_LOOK;
        end
        S_LOOK: begin
          if (fire) begin
            out_status_r <= res_status;
            out_handle_r <= res_handle;
            out_len_r    <= res_len;
            out_key_r    <= '0;
            if (go_read) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            out_key_r <= ram_rd_data;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_key_r, out_len_r, out_handle_r};

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("request accepted while another is in flight");

  // only a successful create carries a handle
  a_handle_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[63:0] == 64'd0))
    else $error("handle reported on failed request");

  // issued local ids are never zero
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[63:0] != 64'd0) |-> (out_tdata[31:0] != 32'd0))
    else $error("zero local id issued");

  // once running, the counter never returns to zero
  a_cnt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |=> (cnt_r != '0))
    else $error("id counter returned to zero");

endmodule
